/* hdl/hcet_pkg.sv */
// Shared types, codes and constants of the hang confirmation and escalation table.
`timescale 1ns / 1ps
`default_nettype none

package hcet_pkg;

    localparam int ENTRIES_DEFAULT = 64;
    localparam int GRACE_SCALE     = 1000;

    localparam int ROUNDS_W   = 16;
    localparam int GRACE_W    = 31;
    localparam int WINDOW_W   = 41;
    localparam int PROC_W     = 23;
    localparam int BACKEND_W  = 18;
    localparam int TIME_W     = 64;
    localparam int INDEX_W    = 6;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [ROUNDS_W-1:0] CONFIRM_RESET = 16'd3;
    localparam logic [GRACE_W-1:0]  GRACE_RESET   = 31'd5000;

    localparam logic [CFG_INDEX_W-1:0] CFG_CONFIRM_ROUNDS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GRACE_MS       = 2'd1;

    localparam logic [1:0] REQ_TOUCH   = 2'd0;
    localparam logic [1:0] REQ_RECORD  = 2'd1;
    localparam logic [1:0] REQ_ROUND   = 2'd2;
    localparam logic [1:0] REQ_IGNORED = 2'd3;

    localparam logic [1:0] STATUS_HIT       = 2'd0;
    localparam logic [1:0] STATUS_NEW       = 2'd1;
    localparam logic [1:0] STATUS_FULL      = 2'd2;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd3;

    localparam logic [1:0] TIER_NONE      = 2'd0;
    localparam logic [1:0] TIER_CANCEL    = 2'd1;
    localparam logic [1:0] TIER_TERMINATE = 2'd2;
    localparam logic [1:0] TIER_DEGRADE   = 2'd3;

    typedef struct packed {
        logic [1:0]               req_type;
        logic [PROC_W-1:0]        proc_id;
        logic [BACKEND_W-1:0]     backend_slot;
        logic signed [TIME_W-1:0] now_us;
        logic [1:0]               applied_tier;
    } in_t;

    typedef struct packed {
        logic [1:0]          status;
        logic [INDEX_W-1:0]  entry_index;
        logic [ROUNDS_W-1:0] rounds_count;
        logic                is_ready;
        logic [1:0]          next_tier;
    } out_t;

endpackage

`default_nettype wire

/* hdl/hcet_tier_judge.sv */
// Escalation decision from the last applied tier and the time since that action.
`timescale 1ns / 1ps
`default_nettype none

module hcet_tier_judge (
    input  wire logic [1:0]                       last_tier,
    input  wire logic [hcet_pkg::TIME_W:0]        elapsed,
    input  wire logic [hcet_pkg::WINDOW_W-1:0]    window,
    output logic      [1:0]                       next_tier
);

    logic passed;

    // The elapsed time is an exact signed difference; a negative one never passes.
    assign passed = !elapsed[hcet_pkg::TIME_W]
                    && (elapsed[hcet_pkg::TIME_W-1:0] >= hcet_pkg::TIME_W'(window));

    always_comb begin
        case (last_tier)
            hcet_pkg::TIER_NONE: begin
                next_tier = hcet_pkg::TIER_CANCEL;
            end
            hcet_pkg::TIER_CANCEL: begin
                next_tier = passed ? hcet_pkg::TIER_TERMINATE : hcet_pkg::TIER_NONE;
            end
            hcet_pkg::TIER_TERMINATE: begin
                next_tier = passed ? hcet_pkg::TIER_DEGRADE : hcet_pkg::TIER_NONE;
            end
            default: begin
                next_tier = hcet_pkg::TIER_DEGRADE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* hdl/hang_confirm_escalation_table.sv */
// Top level of the hang confirmation and escalation table with its scan sequencer.
// Touch and record scan the row memory one entry per cycle through a single read port.
// A hit scans up to its entry k, then passes through the calc, decide and finish steps.
// A miss scans every entry, then decides when it allocates, or goes to finish when it does not.
// A round boundary or unknown type goes straight to finish; finish waits for a free output,
// registers the result and returns to idle. Synchronous active-low reset clears used and seen at once.
`timescale 1ns / 1ps
`default_nettype none

module hang_confirm_escalation_table #(
    parameter int ENTRIES = hcet_pkg::ENTRIES_DEFAULT
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire hcet_pkg::in_t                      s_data,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output hcet_pkg::out_t                          m_data,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [hcet_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [hcet_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SCAN   = 5'b00010,
        ST_CALC   = 5'b00100,
        ST_DECIDE = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    typedef struct packed {
        logic [hcet_pkg::PROC_W-1:0]    proc_id;
        logic [hcet_pkg::BACKEND_W-1:0] backend;
        logic [hcet_pkg::ROUNDS_W-1:0]  rounds;
        logic [1:0]                     tier;
        logic [hcet_pkg::TIME_W-1:0]    action_time;
    } row_t;

    state_t state_reg;

    hcet_pkg::in_t in_reg;
    logic [hcet_pkg::ROUNDS_W-1:0] confirm_reg;
    logic [hcet_pkg::GRACE_W-1:0]  grace_reg;
    logic [hcet_pkg::WINDOW_W-1:0] window_reg;

    logic [ENTRIES-1:0] used_reg;
    logic [ENTRIES-1:0] seen_reg;

    row_t row_mem [0:ENTRIES-1];
    row_t row_q_reg;

    logic [IDX_W-1:0] issue_idx_reg;
    logic             issue_done_reg;
    logic [IDX_W-1:0] chk_idx_reg;
    logic             chk_valid_reg;
    logic [IDX_W-1:0] free_idx_reg;
    logic             free_found_reg;
    logic [IDX_W-1:0] hit_idx_reg;

    logic [hcet_pkg::TIME_W:0] diff_reg;
    logic [1:0]                eval_tier_reg;

    logic [1:0]                    res_status_reg;
    logic [IDX_W-1:0]              res_index_reg;
    logic [hcet_pkg::ROUNDS_W-1:0] res_rounds_reg;
    logic                          res_ready_reg;
    logic [1:0]                    res_tier_reg;

    logic           m_valid_reg;
    hcet_pkg::out_t m_data_reg;

    logic                          key_match;
    logic                          last_chk;
    logic                          rd_en;
    logic                          wr_en;
    logic [IDX_W-1:0]              wr_addr;
    row_t                          wr_row;
    logic                          free_here;
    logic [IDX_W-1:0]              alloc_idx;
    logic [hcet_pkg::ROUNDS_W-1:0] touched_rounds;
    logic [hcet_pkg::TIME_W-1:0]   then_time;
    logic [1:0]                    judged_tier;
    logic                          accept;
    logic                          out_free;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    assign key_match = (state_reg == ST_SCAN) && chk_valid_reg && used_reg[chk_idx_reg]
                       && (row_q_reg.proc_id == in_reg.proc_id)
                       && (row_q_reg.backend == in_reg.backend_slot);
    assign last_chk  = chk_valid_reg && (chk_idx_reg == LAST_IDX);
    assign rd_en     = (state_reg == ST_SCAN) && !issue_done_reg && !key_match;
    assign free_here = chk_valid_reg && !used_reg[chk_idx_reg];
    assign alloc_idx = free_found_reg ? free_idx_reg : chk_idx_reg;

    assign touched_rounds = (seen_reg[hit_idx_reg] || (row_q_reg.rounds == '1))
                            ? row_q_reg.rounds
                            : row_q_reg.rounds + hcet_pkg::ROUNDS_W'(1);
    assign then_time = (in_reg.req_type == hcet_pkg::REQ_TOUCH)
                       ? row_q_reg.action_time : in_reg.now_us;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = hit_idx_reg;
        wr_row  = row_q_reg;
        if (state_reg == ST_SCAN && !key_match && last_chk
            && in_reg.req_type == hcet_pkg::REQ_TOUCH && (free_found_reg || free_here)) begin
            wr_en              = 1'b1;
            wr_addr            = alloc_idx;
            wr_row.proc_id     = in_reg.proc_id;
            wr_row.backend     = in_reg.backend_slot;
            wr_row.rounds      = hcet_pkg::ROUNDS_W'(1);
            wr_row.tier        = hcet_pkg::TIER_NONE;
            wr_row.action_time = '0;
        end else if (state_reg == ST_CALC) begin
            wr_en = 1'b1;
            if (in_reg.req_type == hcet_pkg::REQ_TOUCH) begin
                wr_row.rounds = touched_rounds;
            end else begin
                wr_row.tier        = in_reg.applied_tier;
                wr_row.action_time = in_reg.now_us;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            row_mem[wr_addr] <= wr_row;
        end
        if (rd_en) begin
            row_q_reg <= row_mem[issue_idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        window_reg <= hcet_pkg::WINDOW_W'(grace_reg)
                      * hcet_pkg::WINDOW_W'(hcet_pkg::GRACE_SCALE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            confirm_reg <= hcet_pkg::CONFIRM_RESET;
            grace_reg   <= hcet_pkg::GRACE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                hcet_pkg::CFG_CONFIRM_ROUNDS: begin
                    confirm_reg <= cfg_data[hcet_pkg::ROUNDS_W-1:0];
                end
                hcet_pkg::CFG_GRACE_MS: begin
                    grace_reg <= cfg_data[hcet_pkg::GRACE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    hcet_tier_judge u_judge (
        .last_tier (eval_tier_reg),
        .elapsed   (diff_reg),
        .window    (window_reg),
        .next_tier (judged_tier)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            used_reg    <= '0;
            seen_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && (state_reg != ST_FINISH)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        in_reg         <= s_data;
                        issue_idx_reg  <= '0;
                        issue_done_reg <= 1'b0;
                        chk_valid_reg  <= 1'b0;
                        free_found_reg <= 1'b0;
                        res_status_reg <= hcet_pkg::STATUS_HIT;
                        res_index_reg  <= '0;
                        res_rounds_reg <= '0;
                        res_ready_reg  <= 1'b0;
                        res_tier_reg   <= hcet_pkg::TIER_NONE;
                        case (s_data.req_type) inside
                            hcet_pkg::REQ_TOUCH, hcet_pkg::REQ_RECORD: begin
                                state_reg <= ST_SCAN;
                            end
                            hcet_pkg::REQ_ROUND: begin
                                used_reg  <= used_reg & seen_reg;
                                seen_reg  <= '0;
                                state_reg <= ST_FINISH;
                            end
                            default: begin
                                state_reg <= ST_FINISH;
                            end
                        endcase
                    end
                end
                ST_SCAN: begin
                    if (rd_en) begin
                        chk_idx_reg   <= issue_idx_reg;
                        chk_valid_reg <= 1'b1;
                        if (issue_idx_reg == LAST_IDX) begin
                            issue_done_reg <= 1'b1;
                        end else begin
                            issue_idx_reg <= issue_idx_reg + IDX_W'(1);
                        end
                    end else begin
                        chk_valid_reg <= 1'b0;
                    end
                    if (free_here && !free_found_reg) begin
                        free_found_reg <= 1'b1;
                        free_idx_reg   <= chk_idx_reg;
                    end
                    if (key_match) begin
                        hit_idx_reg <= chk_idx_reg;
                        state_reg   <= ST_CALC;
                    end else if (last_chk) begin
                        if (in_reg.req_type == hcet_pkg::REQ_TOUCH
                            && (free_found_reg || free_here)) begin
                            used_reg[alloc_idx] <= 1'b1;
                            seen_reg[alloc_idx] <= 1'b1;
                            res_status_reg      <= hcet_pkg::STATUS_NEW;
                            res_index_reg       <= alloc_idx;
                            res_rounds_reg      <= hcet_pkg::ROUNDS_W'(1);
                            res_ready_reg       <= (confirm_reg <= hcet_pkg::ROUNDS_W'(1));
                            eval_tier_reg       <= hcet_pkg::TIER_NONE;
                            diff_reg            <= '0;
                            state_reg           <= ST_DECIDE;
                        end else begin
                            res_status_reg <= (in_reg.req_type == hcet_pkg::REQ_TOUCH)
                                              ? hcet_pkg::STATUS_FULL
                                              : hcet_pkg::STATUS_NOT_FOUND;
                            state_reg      <= ST_FINISH;
                        end
                    end
                end
                ST_CALC: begin
                    res_status_reg <= hcet_pkg::STATUS_HIT;
                    res_index_reg  <= hit_idx_reg;
                    diff_reg <= {in_reg.now_us[hcet_pkg::TIME_W-1], in_reg.now_us}
                                - {then_time[hcet_pkg::TIME_W-1], then_time};
                    if (in_reg.req_type == hcet_pkg::REQ_TOUCH) begin
                        seen_reg[hit_idx_reg] <= 1'b1;
                        res_rounds_reg        <= touched_rounds;
                        res_ready_reg         <= (touched_rounds >= confirm_reg);
                        eval_tier_reg         <= row_q_reg.tier;
                    end else begin
                        res_rounds_reg <= row_q_reg.rounds;
                        res_ready_reg  <= (row_q_reg.rounds >= confirm_reg);
                        eval_tier_reg  <= in_reg.applied_tier;
                    end
                    state_reg <= ST_DECIDE;
                end
                ST_DECIDE: begin
                    res_tier_reg <= judged_tier;
                    state_reg    <= ST_FINISH;
                end
                ST_FINISH: begin
                    if (out_free) begin
                        m_valid_reg             <= 1'b1;
                        m_data_reg.status       <= res_status_reg;
                        m_data_reg.entry_index  <= hcet_pkg::INDEX_W'(res_index_reg);
                        m_data_reg.rounds_count <= res_rounds_reg;
                        m_data_reg.is_ready     <= res_ready_reg;
                        m_data_reg.next_tier    <= res_tier_reg;
                        state_reg               <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("request accepted while a request was still in work");

    a_seen_implies_used: assert property (@(posedge aclk) disable iff (!aresetn)
        &(used_reg | ~seen_reg))
        else $error("an entry is marked seen but not in use");

    a_result_from_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_FINISH))
        else $error("result raised outside the finish step");

    a_decide_then_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DECIDE) |=> (state_reg == ST_FINISH))
        else $error("tier decision not followed by the finish step");

    a_single_hit_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CALC) |-> (used_reg[hit_idx_reg] && $past(key_match)))
        else $error("row update without a matching used entry");
`endif

endmodule

`default_nettype wire

/* tb/hcet_table_checker.sv */
// Checker that predicts every result of the escalation table and compares it with the block's.
`timescale 1ns / 1ps

module hcet_table_checker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    input  logic                               s_ready,
    input  hcet_pkg::in_t                      s_data,
    input  logic                               m_valid,
    input  logic                               m_ready,
    input  hcet_pkg::out_t                     m_data,
    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  logic [hcet_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [hcet_pkg::CFG_DATA_W-1:0]    cfg_data,
    output int                                 fail_count,
    output int                                 pending,
    output int                                 results_seen,
    output int                                 full_seen
);
    import hcet_pkg::*;

    localparam int ENTRIES = ENTRIES_DEFAULT;

    logic                 in_use     [ENTRIES];
    logic                 seen_round [ENTRIES];
    logic [PROC_W-1:0]    id_proc    [ENTRIES];
    logic [BACKEND_W-1:0] id_backend [ENTRIES];
    logic [ROUNDS_W-1:0]  round_cnt  [ENTRIES];
    logic [1:0]           last_tier  [ENTRIES];
    logic [TIME_W-1:0]    last_time  [ENTRIES];

    logic [ROUNDS_W-1:0] confirm_cfg;
    logic [GRACE_W-1:0]  grace_cfg;

    out_t expected_results[$];

    function automatic int find_identity(input logic [PROC_W-1:0] p,
                                         input logic [BACKEND_W-1:0] b);
        for (int i = 0; i < ENTRIES; i++) begin
            if (in_use[i] && id_proc[i] == p && id_backend[i] == b) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic logic [1:0] tier_due(input int i, input logic [TIME_W-1:0] now);
        logic [WINDOW_W-1:0] window;
        logic [TIME_W:0]     span;
        logic                passed;
        window = WINDOW_W'(grace_cfg);
        window = window * WINDOW_W'(GRACE_SCALE);
        // The elapsed time is taken one bit wider so that it never wraps.
        span = {now[TIME_W-1], now} - {last_time[i][TIME_W-1], last_time[i]};
        passed = !span[TIME_W] && (span[TIME_W-1:0] >= TIME_W'(window));
        case (last_tier[i])
            TIER_NONE:      return TIER_CANCEL;
            TIER_CANCEL:    return passed ? TIER_TERMINATE : TIER_NONE;
            TIER_TERMINATE: return passed ? TIER_DEGRADE : TIER_NONE;
            default:        return TIER_DEGRADE;
        endcase
    endfunction

    function automatic out_t entry_report(input int i, input logic [TIME_W-1:0] now,
                                          input logic [1:0] st);
        out_t r;
        r.status       = st;
        r.entry_index  = i[INDEX_W-1:0];
        r.rounds_count = round_cnt[i];
        r.is_ready     = (round_cnt[i] >= confirm_cfg);
        r.next_tier    = tier_due(i, now);
        return r;
    endfunction

    task automatic predict_table_result(input in_t req, output out_t res);
        int hit;
        int slot;
        res = '0;
        case (req.req_type)
            REQ_TOUCH: begin
                hit = find_identity(req.proc_id, req.backend_slot);
                if (hit >= 0) begin
                    if (!seen_round[hit]) begin
                        if (round_cnt[hit] != '1) begin
                            round_cnt[hit] = round_cnt[hit] + ROUNDS_W'(1);
                        end
                        seen_round[hit] = 1'b1;
                    end
                    res = entry_report(hit, req.now_us, STATUS_HIT);
                end else begin
                    slot = -1;
                    for (int i = 0; i < ENTRIES && slot < 0; i++) begin
                        if (!in_use[i]) begin
                            slot = i;
                        end
                    end
                    if (slot < 0) begin
                        res.status = STATUS_FULL;
                        full_seen++;
                    end else begin
                        in_use[slot]     = 1'b1;
                        seen_round[slot] = 1'b1;
                        id_proc[slot]    = req.proc_id;
                        id_backend[slot] = req.backend_slot;
                        round_cnt[slot]  = ROUNDS_W'(1);
                        last_tier[slot]  = TIER_NONE;
                        last_time[slot]  = '0;
                        res = entry_report(slot, req.now_us, STATUS_NEW);
                    end
                end
            end
            REQ_RECORD: begin
                hit = find_identity(req.proc_id, req.backend_slot);
                if (hit < 0) begin
                    res.status = STATUS_NOT_FOUND;
                end else begin
                    last_tier[hit] = req.applied_tier;
                    last_time[hit] = req.now_us;
                    res = entry_report(hit, req.now_us, STATUS_HIT);
                end
            end
            REQ_ROUND: begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (in_use[i] && !seen_round[i]) begin
                        in_use[i]    = 1'b0;
                        round_cnt[i] = '0;
                        last_tier[i] = TIER_NONE;
                        last_time[i] = '0;
                    end
                    seen_round[i] = 1'b0;
                end
            end
            default: begin
            end
        endcase
    endtask

    always @(posedge aclk) begin : watch
        out_t want;
        if (!aresetn) begin
            confirm_cfg = CONFIRM_RESET;
            grace_cfg   = GRACE_RESET;
            for (int i = 0; i < ENTRIES; i++) begin
                in_use[i]     = 1'b0;
                seen_round[i] = 1'b0;
                id_proc[i]    = '0;
                id_backend[i] = '0;
                round_cnt[i]  = '0;
                last_tier[i]  = TIER_NONE;
                last_time[i]  = '0;
            end
            expected_results.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_CONFIRM_ROUNDS: confirm_cfg = cfg_data[ROUNDS_W-1:0];
                    CFG_GRACE_MS:       grace_cfg   = cfg_data[GRACE_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("ERROR at %0t: result with no request in flight: %p",
                                 $time, m_data);
                    end
                end else begin
                    want = expected_results.pop_front();
                    if (m_data.status !== want.status ||
                        m_data.entry_index !== want.entry_index ||
                        m_data.rounds_count !== want.rounds_count ||
                        m_data.is_ready !== want.is_ready ||
                        m_data.next_tier !== want.next_tier) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("ERROR at %0t: status %0d/%0d index %0d/%0d rounds %0d/%0d",
                                     $time, want.status, m_data.status, want.entry_index,
                                     m_data.entry_index, want.rounds_count,
                                     m_data.rounds_count);
                            $display("    ready %0d/%0d tier %0d/%0d (expected/actual)",
                                     want.is_ready, m_data.is_ready, want.next_tier,
                                     m_data.next_tier);
                        end
                    end
                end
            end
            if (s_valid && s_ready) begin
                predict_table_result(s_data, want);
                expected_results.push_back(want);
            end
        end
        pending = expected_results.size();
    end

endmodule

/* tb/tb.sv */
// Testbench top for the escalation table: clock, reset, request stimulus and the verdict.
`timescale 1ns / 1ps

module tb;
    import hcet_pkg::*;

    localparam int POOL          = 96;
    localparam int STREAK_ROUNDS = 20;
    localparam logic [TIME_W-1:0] T_MIN = 64'h8000_0000_0000_0000;
    localparam logic [TIME_W-1:0] T_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    in_t                    s_data    = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    out_t                   m_data;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    int fail_count;
    int pending;
    int results_seen;
    int full_seen;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int rx_hold     = 0;
    int n_sent      = 0;

    logic [TIME_W-1:0]    clock_us  = '0;
    logic [TIME_W-1:0]    window_us = '0;
    logic [PROC_W-1:0]    pool_proc    [POOL];
    logic [BACKEND_W-1:0] pool_backend [POOL];

    hang_confirm_escalation_table u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    hcet_table_checker u_watch (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending),
        .results_seen (results_seen),
        .full_seen    (full_seen)
    );

    always #5 aclk = ~aclk;

    initial begin
        forever begin
            @(negedge aclk);
            if (rx_hold > 0) begin
                m_ready <= 1'b0;
                rx_hold = rx_hold - 1;
            end else begin
                m_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    initial begin
        #40_000_000;
        $display("Run stopped at the time limit with %0d results outstanding.", pending);
        $display("Some tests failed");
        $finish;
    end

    task automatic send_req(input logic [1:0] kind, input logic [PROC_W-1:0] p,
                            input logic [BACKEND_W-1:0] b, input logic [TIME_W-1:0] now,
                            input logic [1:0] tier);
        in_t req;
        req.req_type     = kind;
        req.proc_id      = p;
        req.backend_slot = b;
        req.now_us       = now;
        req.applied_tier = tier;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_data  <= req;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        n_sent++;
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
    endtask

    function automatic logic [TIME_W-1:0] rand_upto(input logic [TIME_W-1:0] lim);
        logic [TIME_W-1:0] r;
        r = {$urandom, $urandom};
        return (lim == '1) ? r : r % (lim + 64'd1);
    endfunction

    function automatic logic [TIME_W-1:0] stamp();
        return ($urandom_range(99) < 5) ? {$urandom, $urandom} : clock_us;
    endfunction

    task automatic build_pool();
        for (int k = 0; k < POOL; k++) begin
            pool_proc[k]    = PROC_W'($urandom);
            pool_backend[k] = BACKEND_W'($urandom);
            if (k > 0 && $urandom_range(3) == 0) begin
                pool_proc[k] = pool_proc[k-1];
            end else if (k > 0 && $urandom_range(3) == 0) begin
                pool_backend[k] = pool_backend[k-1];
            end
        end
        pool_proc[0]    = '1;
        pool_backend[0] = '0;
        pool_proc[1]    = '0;
        pool_backend[1] = '1;
        clock_us = {$urandom, $urandom};
    endtask

    task automatic run_rounds(input int n_items);
        int target;
        int width;
        int base;
        int k;
        target = n_sent + n_items;
        while (n_sent < target) begin
            width = ($urandom_range(99) < 15) ? $urandom_range(40, 80) : $urandom_range(0, 16);
            base  = $urandom_range(POOL - 1);
            for (int j = 0; j < width; j++) begin
                if (width > 16) begin
                    k = (base + j) % POOL;
                end else if ($urandom_range(99) < 70) begin
                    k = $urandom_range(11);
                end else begin
                    k = $urandom_range(POOL - 1);
                end
                clock_us = clock_us + rand_upto(window_us >> 3);
                send_req(REQ_TOUCH, pool_proc[k], pool_backend[k], stamp(),
                         2'($urandom_range(3)));
                if ($urandom_range(99) < 40) begin
                    send_req(REQ_RECORD, pool_proc[k], pool_backend[k], stamp(),
                             2'($urandom_range(3)));
                end
                if ($urandom_range(99) < 20) begin
                    send_req(REQ_TOUCH, pool_proc[k], pool_backend[k], stamp(),
                             2'($urandom_range(3)));
                end
                if ($urandom_range(99) < 6) begin
                    send_req(2'($urandom_range(3)), PROC_W'($urandom), BACKEND_W'($urandom),
                             {$urandom, $urandom}, 2'($urandom_range(3)));
                end
                if ($urandom_range(99) < 4) begin
                    send_req(REQ_RECORD, PROC_W'($urandom), BACKEND_W'($urandom), stamp(),
                             2'($urandom_range(3)));
                end
            end
            clock_us = clock_us + rand_upto(window_us);
            send_req(REQ_ROUND, PROC_W'($urandom), BACKEND_W'($urandom),
                     {$urandom, $urandom}, 2'($urandom_range(3)));
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed requests against the reset settings: three rounds, a five second window.
        send_req(REQ_ROUND, '0, '0, '0, TIER_NONE);
        send_req(REQ_IGNORED, '1, '1, '1, TIER_DEGRADE);
        send_req(REQ_RECORD, '1, '1, '0, TIER_TERMINATE);
        send_req(REQ_TOUCH, '1, '1, '0, TIER_NONE);
        send_req(REQ_TOUCH, '1, '1, '0, TIER_NONE);
        send_req(REQ_TOUCH, '0, '0, '0, TIER_NONE);
        send_req(REQ_TOUCH, '1, '0, '0, TIER_NONE);
        send_req(REQ_TOUCH, '0, '1, '0, TIER_NONE);
        send_req(REQ_RECORD, '1, '1, T_MIN, TIER_CANCEL);
        send_req(REQ_ROUND, '0, '0, '0, TIER_NONE);
        send_req(REQ_TOUCH, '1, '1, T_MAX, TIER_NONE);
        send_req(REQ_TOUCH, '0, '0, '0, TIER_NONE);
        send_req(REQ_RECORD, '0, '0, T_MAX, TIER_TERMINATE);
        send_req(REQ_TOUCH, '0, '0, T_MIN, TIER_NONE);
        send_req(REQ_ROUND, '0, '0, '0, TIER_NONE);
        send_req(REQ_TOUCH, '1, '1, T_MAX, TIER_NONE);
        send_req(REQ_RECORD, '1, '1, '0, TIER_DEGRADE);
        send_req(REQ_RECORD, '1, '1, 64'd4_999_999, TIER_NONE);
        send_req(REQ_TOUCH, '0, '1, '0, TIER_NONE);
        send_req(REQ_RECORD, '0, '0, 64'd1000, TIER_TERMINATE);
        send_req(REQ_TOUCH, '0, '0, 64'd5_000_999, TIER_NONE);
        send_req(REQ_TOUCH, '0, '0, 64'd5_001_000, TIER_NONE);
        send_req(REQ_RECORD, 23'd1, '1, '0, TIER_CANCEL);
        send_req(REQ_ROUND, '0, '0, '0, TIER_NONE);
        send_req(REQ_IGNORED, '0, '0, '0, TIER_NONE);
        settle();

        tx_idle_pct = 38;
        rx_idle_pct = 84;
        write_reg(CFG_CONFIRM_ROUNDS, 32'hFFFF_0000);
        write_reg(CFG_GRACE_MS, 32'h8000_0000);
        window_us = '0;
        build_pool();
        run_rounds(480);
        settle();

        tx_idle_pct = 84;
        rx_idle_pct = 38;
        write_reg(CFG_CONFIRM_ROUNDS, 32'h0001_0002);
        write_reg(CFG_GRACE_MS, 32'd1);
        window_us = 64'd1000;
        build_pool();
        run_rounds(480);
        settle();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_reg(CFG_CONFIRM_ROUNDS, 32'd4);
        write_reg(CFG_GRACE_MS, 32'hFFFF_FFFF);
        window_us = 64'd2_147_483_647_000;
        build_pool();
        rx_hold = 400;
        run_rounds(480);
        settle();

        // Two boundaries empty the table, then one identity is carried through a streak of rounds.
        write_reg(CFG_CONFIRM_ROUNDS, 32'h0000_FFFF);
        write_reg(CFG_GRACE_MS, 32'd5000);
        send_req(REQ_ROUND, '0, '0, '0, TIER_NONE);
        send_req(REQ_ROUND, '0, '0, '0, TIER_NONE);
        send_req(REQ_TOUCH, 23'h2A_5A5A, 18'h1_2345, 64'd0, TIER_NONE);
        send_req(REQ_RECORD, 23'h2A_5A5A, 18'h1_2345, 64'd0, TIER_CANCEL);
        for (int r = 0; r < STREAK_ROUNDS; r++) begin
            send_req(REQ_ROUND, '0, '0, '0, TIER_NONE);
            send_req(REQ_TOUCH, 23'h2A_5A5A, 18'h1_2345, 64'(r) * 64'd1000, TIER_NONE);
        end
        settle();

        repeat (ENTRIES_DEFAULT + 10) @(negedge aclk);
        $display("Covered %0d requests: directed cases, three idle mixes with a long output stall,",
                 n_sent);
        $display("and a streak of rounds on one identity; %0d results, %0d table-full replies.",
                 results_seen, full_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
hdl/hcet_pkg.sv
hdl/hcet_tier_judge.sv
hdl/hang_confirm_escalation_table.sv
tb/hcet_table_checker.sv
tb/tb.sv
